>>> rtl/drmt_pkg.sv
// drmt_pkg: shared types and constants of the damage rectangle merge table
// field widths, result status codes and the token that walks the cell chain
// no dependencies
package drmt_pkg;

	// field widths of the request and result channels
	localparam int TYPE_W  = 1;
	localparam int POS_W   = 15;
	localparam int SIZE_W  = 14;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 5;
	localparam int EXT_W   = 16;
	localparam int RCNT_W  = 6;

	// internal coordinate width: left/top plus size always fits signed 16 bits
	localparam int COORD_W = 16;

	// request codes
	localparam logic [TYPE_W-1:0] REQ_MARK  = 1'b0;
	localparam logic [TYPE_W-1:0] REQ_CLEAR = 1'b1;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_MERGED   = 2'd0,
		ST_APPENDED = 2'd1,
		ST_DROPPED  = 2'd2,
		ST_CLEARED  = 2'd3
	} status_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	// token handed from cell to cell, carrying the request rectangle as spans
	typedef struct packed {
		logic              vld;
		logic              done;
		status_t           status;
		logic [SLOT_W-1:0] slot;
		coord_t            xlo;
		coord_t            xhi;
		coord_t            ylo;
		coord_t            yhi;
	} tok_t;

endpackage

>>> rtl/drmt_req_if.sv
// drmt_req_if: request channel of the damage rectangle merge table
// valid/ready handshake with mark/clear request payload
// depends on drmt_pkg
interface drmt_req_if;
	logic                                valid;
	logic                                ready;
	logic [drmt_pkg::TYPE_W-1:0]         req_type;
	logic signed [drmt_pkg::POS_W-1:0]   rect_x;
	logic signed [drmt_pkg::POS_W-1:0]   rect_y;
	logic [drmt_pkg::SIZE_W-1:0]         rect_w;
	logic [drmt_pkg::SIZE_W-1:0]         rect_h;

	modport source (output valid, req_type, rect_x, rect_y, rect_w, rect_h, input ready);
	modport sink   (input valid, req_type, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

>>> rtl/drmt_res_if.sv
// drmt_res_if: result channel of the damage rectangle merge table
// valid/ready handshake with status, slot, stored rectangle and count
// depends on drmt_pkg
interface drmt_res_if;
	logic                                valid;
	logic                                ready;
	logic [drmt_pkg::STAT_W-1:0]         status;
	logic [drmt_pkg::SLOT_W-1:0]         slot;
	logic signed [drmt_pkg::POS_W-1:0]   out_x;
	logic signed [drmt_pkg::POS_W-1:0]   out_y;
	logic [drmt_pkg::EXT_W-1:0]          out_w;
	logic [drmt_pkg::EXT_W-1:0]          out_h;
	logic [drmt_pkg::RCNT_W-1:0]         rect_count;

	modport source (output valid, status, slot, out_x, out_y, out_w, out_h, rect_count,
		input ready);
	modport sink   (input valid, status, slot, out_x, out_y, out_w, out_h, rect_count,
		output ready);
endinterface

>>> rtl/dirty_rect_merge_table_top.sv
// dirty_rect_merge_table_top: damage rectangle table built as a row of slot cells
// a mark request walks the row one cell per cycle when not stalled; clear skips the row
// depends on drmt_pkg, drmt_req_if, drmt_res_if, drmt_cell
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, rect_x, rect_y, rect_w, rect_h
//   res      out  valid/ready   status, slot, out_x, out_y, out_w, out_h, rect_count
//
// a mark result is registered after its transfer: the transfer edge loads the launch register,
// then the token passes the token register of each cell of the row and then the result
// register. busy clears as the result is registered, so the next request is taken only then.
// a clear is written straight into the result register. one request is in the row at a time.
// reset clears the fill count and all valid flags; slot contents stay unknown until
// written and are never read before that. a stalled result holds the row at its end.
module dirty_rect_merge_table_top #(
	parameter int MAX_RECTS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	drmt_req_if.sink   req,
	drmt_res_if.source res
);

	localparam int CNT_W = $clog2(MAX_RECTS + 1);

	drmt_pkg::tok_t   chain [MAX_RECTS+1];
	drmt_pkg::tok_t   launch_q;
	drmt_pkg::tok_t   launch_d;
	drmt_pkg::tok_t   tail;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             busy_q;
	logic             res_vld_q;
	logic             en, take, acc, acc_mark, acc_clear, exit_now, res_free;
	drmt_pkg::coord_t x_ext, y_ext;

	logic [drmt_pkg::STAT_W-1:0]       status_q;
	logic [drmt_pkg::SLOT_W-1:0]       slot_q;
	logic signed [drmt_pkg::POS_W-1:0] out_x_q, out_y_q;
	logic [drmt_pkg::EXT_W-1:0]        out_w_q, out_h_q;
	logic [drmt_pkg::RCNT_W-1:0]       rect_count_q;

	// handshake
	assign tail      = chain[MAX_RECTS];
	assign take      = res_vld_q && res.ready;
	assign res_free  = !res_vld_q || res.ready;
	assign en        = !(tail.vld && !res_free);
	assign req.ready = !busy_q && res_free;
	assign acc       = req.valid && req.ready;
	assign acc_mark  = acc && (req.req_type == drmt_pkg::REQ_MARK);
	assign acc_clear = acc && (req.req_type == drmt_pkg::REQ_CLEAR);
	assign exit_now  = tail.vld && en;

	// request rectangle as spans
	assign x_ext = drmt_pkg::coord_t'(req.rect_x);
	assign y_ext = drmt_pkg::coord_t'(req.rect_y);

	always_comb begin
		launch_d        = '0;
		launch_d.vld    = acc_mark;
		launch_d.status = drmt_pkg::ST_DROPPED;
		launch_d.xlo    = x_ext;
		launch_d.xhi    = x_ext + drmt_pkg::coord_t'({1'b0, req.rect_w});
		launch_d.ylo    = y_ext;
		launch_d.yhi    = y_ext + drmt_pkg::coord_t'({1'b0, req.rect_h});
	end

	// launch register feeding the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
		end else if (en) begin
			launch_q <= launch_d;
		end
	end

	assign chain[0] = launch_q;

	// row of slot cells
	for (genvar g = 0; g < MAX_RECTS; g++) begin : g_cell
		drmt_cell #(
			.IDX   (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.count  (count_q),
			.tin    (chain[g]),
			.tout   (chain[g+1])
		);
	end

	// fill count after the request leaving the row
	assign count_nxt = (tail.done && tail.status == drmt_pkg::ST_APPENDED) ?
		count_q + CNT_W'(1) : count_q;

	// busy flag and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (acc_mark) begin
				busy_q <= 1'b1;
			end else if (exit_now) begin
				busy_q <= 1'b0;
			end
			if (acc_clear) begin
				count_q <= '0;
			end else if (exit_now) begin
				count_q <= count_nxt;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (acc_clear || exit_now) begin
			res_vld_q <= 1'b1;
		end else if (take) begin
			res_vld_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc_clear) begin
			status_q     <= drmt_pkg::ST_CLEARED;
			slot_q       <= '0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_w_q      <= '0;
			out_h_q      <= '0;
			rect_count_q <= '0;
		end else if (exit_now) begin
			status_q     <= tail.done ? tail.status : drmt_pkg::ST_DROPPED;
			slot_q       <= tail.done ? tail.slot : '0;
			out_x_q      <= tail.xlo[drmt_pkg::POS_W-1:0];
			out_y_q      <= tail.ylo[drmt_pkg::POS_W-1:0];
			out_w_q      <= drmt_pkg::EXT_W'(tail.xhi - tail.xlo);
			out_h_q      <= drmt_pkg::EXT_W'(tail.yhi - tail.ylo);
			rect_count_q <= drmt_pkg::RCNT_W'(count_nxt);
		end
	end

	assign res.valid      = res_vld_q;
	assign res.status     = status_q;
	assign res.slot       = slot_q;
	assign res.out_x      = out_x_q;
	assign res.out_y      = out_y_q;
	assign res.out_w      = out_w_q;
	assign res.out_h      = out_h_q;
	assign res.rect_count = rect_count_q;

endmodule

>>> rtl/drmt_cell.sv
// drmt_cell: one table slot holding a stored rectangle as x and y spans
// tests the passing token for overlap, merges or appends, hands it on
// depends on drmt_pkg
module drmt_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [CNT_W-1:0] count,
	input  drmt_pkg::tok_t   tin,
	output drmt_pkg::tok_t   tout
);

	localparam logic [CNT_W-1:0]            MY_IDX  = CNT_W'(IDX);
	localparam logic [drmt_pkg::SLOT_W-1:0] MY_SLOT = drmt_pkg::SLOT_W'(IDX);

	drmt_pkg::coord_t xlo_q, xhi_q, ylo_q, yhi_q;
	drmt_pkg::tok_t   tok_q;
	drmt_pkg::tok_t   nxt;
	logic             live, occupied, is_next_free, overlap, wr;

	// slot state relative to the current fill count
	assign live         = tin.vld && !tin.done;
	assign occupied     = count > MY_IDX;
	assign is_next_free = count == MY_IDX;

	// strict overlap of the token rectangle with the stored one
	assign overlap = (tin.xlo < xhi_q) && (tin.xhi > xlo_q) &&
		(tin.ylo < yhi_q) && (tin.yhi > ylo_q);

	// merge into this slot, append here, or pass the token on unchanged
	always_comb begin
		nxt = tin;
		wr  = 1'b0;
		if (live && occupied && overlap) begin
			nxt.done   = 1'b1;
			nxt.status = drmt_pkg::ST_MERGED;
			nxt.slot   = MY_SLOT;
			nxt.xlo    = (tin.xlo < xlo_q) ? tin.xlo : xlo_q;
			nxt.xhi    = (tin.xhi > xhi_q) ? tin.xhi : xhi_q;
			nxt.ylo    = (tin.ylo < ylo_q) ? tin.ylo : ylo_q;
			nxt.yhi    = (tin.yhi > yhi_q) ? tin.yhi : yhi_q;
			wr         = 1'b1;
		end else if (live && is_next_free) begin
			nxt.done   = 1'b1;
			nxt.status = drmt_pkg::ST_APPENDED;
			nxt.slot   = MY_SLOT;
			wr         = 1'b1;
		end
	end

	// stored rectangle, valid only below the fill count
	always_ff @(posedge clk) begin
		if (en && wr) begin
			xlo_q <= nxt.xlo;
			xhi_q <= nxt.xhi;
			ylo_q <= nxt.ylo;
			yhi_q <= nxt.yhi;
		end
	end

	// token register toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (en) begin
			tok_q <= nxt;
		end
	end

	assign tout = tok_q;

endmodule
